@@ rtl/jsu_pkg.sv @@
// shared types, constants and helper functions for the json string unescaper
`default_nettype none
package jsu_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int REPORT_BITS = 24;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [15:0] HI_SUR_LO = 16'hd800;
  localparam logic [15:0] HI_SUR_HI = 16'hdbff;
  localparam logic [15:0] LO_SUR_LO = 16'hdc00;
  localparam logic [15:0] LO_SUR_HI = 16'hdfff;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_BODY    = 4'd1,
    PH_ESC     = 4'd2,
    PH_HEX1    = 4'd3,
    PH_PAIR_BS = 4'd4,
    PH_PAIR_U  = 4'd5,
    PH_HEX2    = 4'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  // one queue entry: a group of results caused by one input word
  typedef struct packed {
    status_t         kind;
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
    logic [REPORT_BITS-1:0] len;
  } record_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] bytes;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(logic [20:0] cp);
    utf8_t u;
    u.n     = 3'd0;
    u.bytes = '0;
    if (cp <= 21'h7f) begin
      u.n        = 3'd1;
      u.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7ff) begin
      u.n        = 3'd2;
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      u.n        = 3'd3;
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      u.n        = 3'd4;
      u.bytes[0] = {5'b11110, cp[20:18]};
      u.bytes[1] = {2'b10, cp[17:12]};
      u.bytes[2] = {2'b10, cp[11:6]};
      u.bytes[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage
`default_nettype wire

@@ rtl/jsu_front.sv @@
// front end: parses the text stream and turns each input word into a result record
`default_nettype none
module jsu_front
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] text_byte,
  input  wire logic       buffer_end,
  output logic            push,
  output record_t         push_rec
);

  phase_t                 phase, phase_next;
  logic [1:0]             hex_digits_seen, hex_digits_seen_next;
  logic [15:0]            hex_accumulator, hex_accumulator_next;
  logic [9:0]             high_surrogate, high_surrogate_next;
  logic [LENGTH_BITS-1:0] byte_count, byte_count_next;

  status_t         term;
  logic            term_any;
  logic [2:0]      nb;
  logic [3:0][7:0] ob;
  hex_t            hv;
  logic [15:0]     acc_new;
  utf8_t           enc;
  logic [LENGTH_BITS:0] sum;
  logic [32:0]     cnt_wide;
  logic [REPORT_BITS-1:0] rep;

  assign hv      = hex_value(text_byte);
  assign acc_new = {hex_accumulator[11:0], hv.val};

  always_comb begin
    phase_next           = phase;
    hex_digits_seen_next = hex_digits_seen;
    hex_accumulator_next = hex_accumulator;
    high_surrogate_next  = high_surrogate;
    term                 = ST_DATA;
    term_any             = 1'b0;
    nb                   = 3'd0;
    ob                   = '0;
    enc                  = '0;

    if (phase != PH_IDLE && text_byte < CH_SPACE) begin
      term     = ST_ERR;
      term_any = 1'b1;
    end else begin
      unique case (phase) inside
        PH_BODY: begin
          if (text_byte == CH_QUOTE) begin
            term     = ST_DONE;
            term_any = 1'b1;
          end else if (text_byte == CH_BSL) begin
            phase_next = PH_ESC;
          end else begin
            nb    = 3'd1;
            ob[0] = text_byte;
          end
        end
        PH_ESC: begin
          phase_next = PH_BODY;
          nb         = 3'd1;
          case (text_byte) inside
            CH_QUOTE, CH_BSL, CH_SLASH: ob[0] = text_byte;
            CH_B: ob[0] = 8'h08;
            CH_F: ob[0] = 8'h0c;
            CH_N: ob[0] = 8'h0a;
            CH_R: ob[0] = 8'h0d;
            CH_T: ob[0] = 8'h09;
            CH_U: begin
              nb                   = 3'd0;
              phase_next           = PH_HEX1;
              hex_digits_seen_next = 2'd0;
              hex_accumulator_next = 16'd0;
            end
            default: begin
              nb       = 3'd0;
              term     = ST_ERR;
              term_any = 1'b1;
            end
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          if (!hv.ok) begin
            term     = ST_ERR;
            term_any = 1'b1;
          end else if (hex_digits_seen != 2'd3) begin
            hex_digits_seen_next = hex_digits_seen + 2'd1;
            hex_accumulator_next = acc_new;
          end else begin
            hex_digits_seen_next = 2'd0;
            hex_accumulator_next = 16'd0;
            if (phase == PH_HEX1) begin
              if (acc_new >= HI_SUR_LO && acc_new <= HI_SUR_HI) begin
                high_surrogate_next = acc_new[9:0];
                phase_next          = PH_PAIR_BS;
              end else if (acc_new >= LO_SUR_LO && acc_new <= LO_SUR_HI) begin
                term     = ST_ERR;
                term_any = 1'b1;
              end else begin
                enc        = utf8_encode({5'd0, acc_new});
                nb         = enc.n;
                ob         = enc.bytes;
                phase_next = PH_BODY;
              end
            end else begin
              if (acc_new >= LO_SUR_LO && acc_new <= LO_SUR_HI) begin
                // supplementary plane code point from the surrogate pair
                enc        = utf8_encode(21'h10000 + {1'b0, high_surrogate, acc_new[9:0]});
                nb         = enc.n;
                ob         = enc.bytes;
                phase_next = PH_BODY;
              end else begin
                term     = ST_ERR;
                term_any = 1'b1;
              end
            end
          end
        end
        PH_PAIR_BS: begin
          if (text_byte == CH_BSL) begin
            phase_next = PH_PAIR_U;
          end else begin
            term     = ST_ERR;
            term_any = 1'b1;
          end
        end
        PH_PAIR_U: begin
          if (text_byte == CH_U) begin
            phase_next           = PH_HEX2;
            hex_digits_seen_next = 2'd0;
            hex_accumulator_next = 16'd0;
          end else begin
            term     = ST_ERR;
            term_any = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
          if (text_byte == CH_QUOTE) begin
            phase_next           = PH_BODY;
            hex_digits_seen_next = 2'd0;
            hex_accumulator_next = 16'd0;
            high_surrogate_next  = 10'd0;
          end else if (text_byte != CH_SPACE && text_byte != CH_TAB &&
                       text_byte != CH_CR && text_byte != CH_LF) begin
            term     = ST_ERR;
            term_any = 1'b1;
          end
        end
      endcase
    end

    // running out of text before the closing quote
    if (!term_any && buffer_end) begin
      term     = ST_ERR;
      term_any = 1'b1;
    end

    if (term_any) begin
      phase_next           = PH_IDLE;
      hex_digits_seen_next = 2'd0;
      hex_accumulator_next = 16'd0;
      high_surrogate_next  = 10'd0;
    end
  end

  // saturating byte counter, cleared by an opening quote
  assign sum = {1'b0, byte_count} + (LENGTH_BITS + 1)'(nb);

  always_comb begin
    if (phase != PH_BODY && phase != PH_ESC && phase != PH_HEX1 &&
        phase != PH_HEX2 && phase != PH_PAIR_BS && phase != PH_PAIR_U &&
        text_byte == CH_QUOTE) begin
      byte_count_next = '0;
    end else if (sum[LENGTH_BITS]) begin
      byte_count_next = '1;
    end else begin
      byte_count_next = sum[LENGTH_BITS-1:0];
    end
  end

  assign cnt_wide = 33'(byte_count);
  assign rep      = (cnt_wide > 33'(24'hffffff)) ? '1 : cnt_wide[REPORT_BITS-1:0];

  always_comb begin
    push_rec = '0;
    push     = 1'b0;
    if (term_any) begin
      push          = accept;
      push_rec.kind = term;
      if (term == ST_DONE) begin
        push_rec.len = rep;
      end
    end else if (nb != 3'd0) begin
      push              = accept;
      push_rec.kind     = ST_DATA;
      push_rec.last_idx = 2'(nb - 3'd1);
      push_rec.bytes    = ob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      hex_digits_seen <= 2'd0;
      hex_accumulator <= 16'd0;
      high_surrogate  <= 10'd0;
      byte_count      <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      hex_digits_seen <= hex_digits_seen_next;
      hex_accumulator <= hex_accumulator_next;
      high_surrogate  <= high_surrogate_next;
      byte_count      <= byte_count_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/jsu_fifo.sv @@
// short record queue between the parser and the output sequencer
`default_nettype none
module jsu_fifo
  import jsu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire record_t push_rec,
  input  wire logic    pop,
  output logic         full,
  output logic         empty,
  output record_t      head
);

  record_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full  = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/jsu_back.sv @@
// back end: walks each queued record out one result word at a time
`default_nettype none
module jsu_back
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fifo_empty,
  input  wire record_t    fifo_head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      status,
  output logic [23:0]     decoded_length,
  output logic            last
);

  logic       busy;
  logic [1:0] idx;
  record_t    rec;
  logic       take, rec_done;

  assign out_valid = busy;
  assign take      = busy && !out_stall;
  assign rec_done  = take && (idx == rec.last_idx);
  assign pop       = (!busy || rec_done) && !fifo_empty;

  assign out_byte       = (rec.kind == ST_DATA) ? rec.bytes[idx] : 8'd0;
  assign status         = rec.kind;
  assign decoded_length = (rec.kind == ST_DONE) ? rec.len : 24'd0;
  assign last           = (idx == rec.last_idx);

  always_ff @(posedge clk) begin
    if (pop) begin
      rec <= fifo_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (rec_done) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/json_string_unescape_utf8.sv @@
// each result word is held in the record queue, then in the output record register
// throughput: one text byte per cycle; a unicode escape expands to up to four output
// words, drained by the output sequencer one per cycle unless out_stall is set,
// from a four-entry record queue; the input stalls only while that queue is full
// reset (rst, synchronous): parser returns to idle, queue and output register empty
`default_nettype none
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  text_byte,
  input  wire logic        buffer_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [1:0]       status,
  output logic [23:0]      decoded_length,
  output logic             last
);

  logic    accept, push, pop, full, empty;
  record_t push_rec, head;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_byte  (text_byte),
    .buffer_end (buffer_end),
    .push       (push),
    .push_rec   (push_rec)
  );

  jsu_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .fifo_empty     (empty),
    .fifo_head      (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .status         (status),
    .decoded_length (decoded_length),
    .last           (last)
  );

  // done and error words always close their group
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DATA |-> last)
    else $error("done or error word without last");

  // a data word never carries a length
  a_data_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DATA |-> decoded_length == 24'd0)
    else $error("data word with nonzero length");

  // a record is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue overflow");

  // output word held while stalled is not replaced by a new record
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_byte))
    else $error("stalled output word changed");

endmodule
`default_nettype wire
